### src/rgb_to_nv12_converter_macros.svh
// Assertion macros for the RGB to NV12 converter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RGB_TO_NV12_CONVERTER_MACROS_SVH
`define RGB_TO_NV12_CONVERTER_MACROS_SVH

// Same-cycle implication
`define RGBNV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RGBNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rgbnv_pkg.sv
// Shared types, constants and color-space functions for the RGB to NV12 converter.
// No dependencies.
package rgbnv_pkg;

  // Configuration port
  localparam int unsigned LW_W   = 14;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [LW_W-1:0]     LINE_WIDTH_RST = 14'd64;
  localparam logic [APB_AW-3:0]   REG_LINE_WIDTH = '0;

  localparam int unsigned CCOL_W = 12;

  // Pixel and horizontal pair sum, red in the low bits
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    logic [8:0] b;
    logic [8:0] g;
    logic [8:0] r;
  } psum_t;

  // Item held between the front stage and the output stage
  typedef struct packed {
    pix_t              pix;
    psum_t             sum;
    logic              chroma;
    logic [CCOL_W-1:0] ccol;
  } stage_t;

  typedef struct packed {
    logic   vld;
    stage_t data;
  } s1_t;

  // BT.601 studio-range coefficients
  localparam int unsigned MW = 18;
  typedef logic signed [MW-1:0] acc_t;

  localparam acc_t KY_R  =  18'sd66;
  localparam acc_t KY_G  =  18'sd129;
  localparam acc_t KY_B  =  18'sd25;
  localparam acc_t KCB_R = -18'sd38;
  localparam acc_t KCB_G = -18'sd74;
  localparam acc_t KCB_B =  18'sd112;
  localparam acc_t KCR_R =  18'sd112;
  localparam acc_t KCR_G = -18'sd94;
  localparam acc_t KCR_B = -18'sd18;
  localparam acc_t RND   =  18'sd128;
  localparam acc_t Y_OFS =  18'sd16;
  localparam acc_t C_OFS =  18'sd128;
  localparam acc_t BYTE_MAX = 18'sd255;

  // Weighted sum of three unsigned bytes plus rounding term
  function automatic acc_t dot3(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c, input acc_t ka,
                                input acc_t kb, input acc_t kc);
    acc_t ea;
    acc_t eb;
    acc_t ec;
    ea = signed'({{(MW-8){1'b0}}, a});
    eb = signed'({{(MW-8){1'b0}}, b});
    ec = signed'({{(MW-8){1'b0}}, c});
    return ea * ka + eb * kb + ec * kc + RND;
  endfunction

  function automatic logic [7:0] sat_byte(input acc_t v);
    logic [7:0] res;
    if (v < 18'sd0) begin
      res = 8'd0;
    end else if (v > BYTE_MAX) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // >>> on a signed value floors, as the spec requires for negatives
  function automatic logic [7:0] luma_of(input pix_t p);
    acc_t s;
    s = dot3(p.r, p.g, p.b, KY_R, KY_G, KY_B);
    return sat_byte((s >>> 8) + Y_OFS);
  endfunction

  function automatic logic [7:0] cb_of(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    acc_t s;
    s = dot3(r, g, b, KCB_R, KCB_G, KCB_B);
    return sat_byte((s >>> 8) + C_OFS);
  endfunction

  function automatic logic [7:0] cr_of(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    acc_t s;
    s = dot3(r, g, b, KCR_R, KCR_G, KCR_B);
    return sat_byte((s >>> 8) + C_OFS);
  endfunction

endpackage

### src/rgbnv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbnv_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while not enabled
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rgbnv_cfg.sv
// APB register block: line_width register and the effective row width.
// Depends on rgbnv_pkg.
module rgbnv_cfg import rgbnv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 8192,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH),
  localparam int unsigned CMP_W    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CMP_W-1:0]  width_o
);

  localparam logic [CMP_W-1:0] MaxEven = CMP_W'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [CMP_W-1:0] MinW    = CMP_W'(2);

  logic [LW_W-1:0]  lw_q;
  logic             sel_lw;
  logic             wr;
  logic [CMP_W-1:0] even_w;

  assign pready = 1'b1;
  assign sel_lw = (paddr[APB_AW-1:2] == REG_LINE_WIDTH);
  assign wr     = psel & penable & pwrite & pready & sel_lw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= LINE_WIDTH_RST;
    end else if (wr) begin
      lw_q <= pwdata[LW_W-1:0];
    end
  end

  assign prdata = sel_lw ? APB_DW'(lw_q) : '0;

  // Width in use: bit 0 dropped, at least two, at most the line store size
  assign even_w = CMP_W'({lw_q[LW_W-1:1], 1'b0});

  always_comb begin
    if (even_w < MinW) begin
      width_o = MinW;
    end else if (even_w > MaxEven) begin
      width_o = MaxEven;
    end else begin
      width_o = even_w;
    end
  end

endmodule

### src/rgbnv_front.sv
// Input stage: position counters, horizontal pair sums and the line store.
// Depends on rgbnv_pkg and rgbnv_ram.
module rgbnv_front import rgbnv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 8192,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH),
  localparam int unsigned CMP_W    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic             start_of_frame_i,
  input  logic [CMP_W-1:0] width_i,
  input  logic             take_i,
  output s1_t              s1_o,
  output psum_t            line_o
);

  localparam int unsigned SLOT_W     = COL_W - 1;
  localparam int unsigned HALF_DEPTH = (MAX_WIDTH + 1) / 2;

  logic [COL_W-1:0]        col_q;
  logic [COL_W-1:0]        col_cur;
  logic [COL_W:0]          col_inc;
  logic                    odd_q;
  logic                    row_cur;
  logic                    wrap;
  logic                    accept;
  logic [SLOT_W-1:0]       slot;
  logic [CCOL_W+SLOT_W-1:0] ccol_ext;
  logic                    vld_q;
  stage_t                  data_q;
  stage_t                  data_d;
  pix_t                    pix;
  pix_t                    left_q;
  psum_t                   sum;
  logic                    line_we;
  logic                    line_re;

  assign in_ready_o = ~vld_q | take_i;
  assign accept     = in_valid_i & in_ready_o;

  // Position of this item; start of frame forces row 0, column 0
  assign col_cur = start_of_frame_i ? '0 : col_q;
  assign row_cur = start_of_frame_i ? 1'b0 : odd_q;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign wrap    = (CMP_W'(col_inc) >= width_i);
  assign slot    = col_cur[COL_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else if (accept) begin
      if (wrap) begin
        col_q <= '0;
        odd_q <= ~row_cur;
      end else begin
        col_q <= col_inc[COL_W-1:0];
        odd_q <= row_cur;
      end
    end
  end

  // Pair sum of the left (even column) pixel and this one
  always_comb begin
    pix.r = red_i;
    pix.g = green_i;
    pix.b = blue_i;
    sum.r = {1'b0, left_q.r} + {1'b0, red_i};
    sum.g = {1'b0, left_q.g} + {1'b0, green_i};
    sum.b = {1'b0, left_q.b} + {1'b0, blue_i};
  end

  always_ff @(posedge clk_i) begin
    if (accept && !col_cur[0]) begin
      left_q <= pix;
    end
  end

  // Even row stores pair sums, odd row reads them back for the block
  assign line_we = accept & col_cur[0] & ~row_cur;
  assign line_re = accept & col_cur[0] & row_cur;

  rgbnv_ram #(
    .WIDTH ($bits(psum_t)),
    .DEPTH (HALF_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (slot),
    .wdata_i (sum),
    .re_i    (line_re),
    .raddr_i (slot),
    .rdata_o (line_o)
  );

  // Stage register
  assign ccol_ext = {{CCOL_W{1'b0}}, slot};

  always_comb begin
    data_d.pix    = pix;
    data_d.sum    = sum;
    data_d.chroma = col_cur[0] & row_cur;
    data_d.ccol   = ccol_ext[CCOL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign s1_o.vld  = vld_q;
  assign s1_o.data = data_q;

endmodule

### src/rgbnv_back.sv
// Output stage: luma, 2x2 average, Cb/Cr and the result register.
// Depends on rgbnv_pkg.
module rgbnv_back import rgbnv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  s1_t               s1_i,
  input  psum_t             line_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        luma_o,
  output logic              chroma_valid_o,
  output logic [7:0]        chroma_blue_o,
  output logic [7:0]        chroma_red_o,
  output logic [CCOL_W-1:0] chroma_column_o
);

  logic              ovld_q;
  logic [9:0]        tot_r;
  logic [9:0]        tot_g;
  logic [9:0]        tot_b;
  logic [7:0]        luma_q;
  logic              cv_q;
  logic [7:0]        cb_q;
  logic [7:0]        cr_q;
  logic [CCOL_W-1:0] ccol_q;

  assign take_o = s1_i.vld & (~ovld_q | out_ready_i);

  // Four-pixel sums; the truncated average is the top eight bits
  assign tot_r = {1'b0, s1_i.data.sum.r} + {1'b0, line_i.r};
  assign tot_g = {1'b0, s1_i.data.sum.g} + {1'b0, line_i.g};
  assign tot_b = {1'b0, s1_i.data.sum.b} + {1'b0, line_i.b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (take_o) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  // Result register; chroma fields read zero without a completed block
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      luma_q <= luma_of(s1_i.data.pix);
      cv_q   <= s1_i.data.chroma;
      if (s1_i.data.chroma) begin
        cb_q   <= cb_of(tot_r[9:2], tot_g[9:2], tot_b[9:2]);
        cr_q   <= cr_of(tot_r[9:2], tot_g[9:2], tot_b[9:2]);
        ccol_q <= s1_i.data.ccol;
      end else begin
        cb_q   <= 8'd0;
        cr_q   <= 8'd0;
        ccol_q <= '0;
      end
    end
  end

  assign out_valid_o     = ovld_q;
  assign luma_o          = luma_q;
  assign chroma_valid_o  = cv_q;
  assign chroma_blue_o   = cb_q;
  assign chroma_red_o    = cr_q;
  assign chroma_column_o = ccol_q;

endmodule

### src/rgb_to_nv12_converter.sv
// Channel   | Handshake                  | Payload
// in        | in_valid_i / in_ready_o    | red_i, green_i, blue_i, start_of_frame_i
// out       | out_valid_o / out_ready_i  | luma_o, chroma_valid_o, chroma_blue_o,
//           |                            | chroma_red_o, chroma_column_o
// apb cfg   | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock sustained while the output is not stalled: an item enters the input stage
// register (line store read issued) at its accepting edge, then the result register when taken.
// The line store has one write and one registered read port, each used at most once per item.
// Reset clears counters and valid flags and loads the line_width default; line store contents
// are undefined until an even row writes them, and there is no clearing pass.
// A stalled output holds its result; the input keeps accepting until both stages are full.
`include "rgb_to_nv12_converter_macros.svh"

// Top level of the RGB to NV12 (BT.601) pixel converter.
// Depends on rgbnv_pkg, rgbnv_cfg, rgbnv_front, rgbnv_back and the assertion macros header.
module rgb_to_nv12_converter import rgbnv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Pixel input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic              start_of_frame_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        luma_o,
  output logic              chroma_valid_o,
  output logic [7:0]        chroma_blue_o,
  output logic [7:0]        chroma_red_o,
  output logic [CCOL_W-1:0] chroma_column_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

  logic [CMP_W-1:0] width;
  logic             take;
  s1_t              s1;
  psum_t            line;
  logic             chroma_clear;
  logic             out_free;
  logic             in_fire;

  rgbnv_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width_o (width)
  );

  rgbnv_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .start_of_frame_i (start_of_frame_i),
    .width_i          (width),
    .take_i           (take),
    .s1_o             (s1),
    .line_o           (line)
  );

  rgbnv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_i            (s1),
    .line_i          (line),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .luma_o          (luma_o),
    .chroma_valid_o  (chroma_valid_o),
    .chroma_blue_o   (chroma_blue_o),
    .chroma_red_o    (chroma_red_o),
    .chroma_column_o (chroma_column_o)
  );

  // Assertions
  assign chroma_clear = (chroma_blue_o == 8'd0) && (chroma_red_o == 8'd0) &&
                        (chroma_column_o == '0);
  assign out_free     = !out_valid_o || out_ready_i;
  assign in_fire      = in_valid_i && in_ready_o;

  `RGBNV_ASSERT_SAME(a_chroma_zero, out_valid_o && !chroma_valid_o, chroma_clear, "chroma not zero")
  `RGBNV_ASSERT_SAME(a_luma_range, out_valid_o, luma_o >= 8'd16 && luma_o <= 8'd235, "bad luma")
  `RGBNV_ASSERT_SAME(a_stall_full, !in_ready_o, !out_free, "needless stall")
  `RGBNV_ASSERT_NEXT(a_ready_follows, in_fire, in_ready_o == out_free, "ready mismatch")

endmodule
